// ===== rtl/tlca_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlca_pkg
// Shared constants and types for the lowest common ancestor block.
// ----------------------------------------------------------------------------
package tlca_pkg;

    localparam int CMD_W   = 2;
    localparam int NODE_W  = 10;
    localparam int DEPTH_W = 11;
    localparam int LEN_W   = 11;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_LEVELS    = 11;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    typedef struct packed {
        logic               present;
        logic               reached;
        logic [DEPTH_W-1:0] depth;
        logic [NODE_W-1:0]  parent;
    } t_node_word;

endpackage
`default_nettype wire

// ===== rtl/tree_lca_binary_lifting.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting
// Rooted tree store with a binary-lifting ancestor table and LCA queries.
// ----------------------------------------------------------------------------
// The block holds one word per node (parent, present, reached, depth) in a
// node memory and the ancestor table in a second memory with two read ports.
// After reset a clearing pass runs through the node memory and no beat is
// accepted until it ends. A load beat with a node in range is written to the
// node memory as it is accepted. A query is paced by the lifting loops, which
// read the ancestor table one level at a time with a wait state after each
// read. A build resets the reachability marks, then runs relaxation sweeps
// until a sweep changes nothing, at most (greatest depth + 1) sweeps, then
// fills level zero and each further level of the table in turn, all limited
// by the single-word memory accesses of each step. One beat is handled at a
// time; a finished result waits in the output register while the next beat
// is accepted.
module tree_lca_binary_lifting #(
    parameter int MAX_NODES = tlca_pkg::DEF_MAX_NODES,
    parameter int LEVELS    = tlca_pkg::DEF_LEVELS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // Fields from bit 0: node_a (10), node_b (10), zero fill.
    input  wire logic [tlca_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // Fields from bit 0: cmd (2).
    input  wire logic [tlca_pkg::CMD_W-1:0]         s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // Fields from bit 0: ancestor (10), path_length (11), zero fill.
    output logic [tlca_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // Fields from bit 0: fault (1).
    output logic [0:0]                              m_axis_tuser
);

    localparam int AW   = $clog2(MAX_NODES);
    localparam int LW   = $clog2(LEVELS);
    localparam int NW   = tlca_pkg::NODE_W;
    localparam int DW   = tlca_pkg::DEPTH_W;
    localparam int PADW = tlca_pkg::OUT_TDATA_W - tlca_pkg::NODE_W - tlca_pkg::LEN_W;

    typedef logic [AW-1:0]     t_addr;
    typedef logic [LW-1:0]     t_lvl;
    typedef logic [LEVELS-1:0] t_lift;
    typedef logic [NW-1:0]     t_node;

    localparam t_addr LAST_NODE = t_addr'(MAX_NODES - 1);
    localparam t_lvl  TOP_LVL   = t_lvl'(LEVELS - 1);

    localparam logic [4:0] ST_INIT    = 5'd0;
    localparam logic [4:0] ST_IDLE    = 5'd1;
    localparam logic [4:0] ST_B_RD    = 5'd2;
    localparam logic [4:0] ST_B_CHK   = 5'd3;
    localparam logic [4:0] ST_CL_RD   = 5'd4;
    localparam logic [4:0] ST_CL_WR   = 5'd5;
    localparam logic [4:0] ST_RX_RD   = 5'd6;
    localparam logic [4:0] ST_RX_PAR  = 5'd7;
    localparam logic [4:0] ST_RX_UPD  = 5'd8;
    localparam logic [4:0] ST_L0_RD   = 5'd9;
    localparam logic [4:0] ST_L0_WR   = 5'd10;
    localparam logic [4:0] ST_LN_RD   = 5'd11;
    localparam logic [4:0] ST_LN_RD2  = 5'd12;
    localparam logic [4:0] ST_LN_WR   = 5'd13;
    localparam logic [4:0] ST_Q_RD    = 5'd14;
    localparam logic [4:0] ST_Q_CHK   = 5'd15;
    localparam logic [4:0] ST_Q_LIFT  = 5'd16;
    localparam logic [4:0] ST_Q_LIFTW = 5'd17;
    localparam logic [4:0] ST_Q_CMP   = 5'd18;
    localparam logic [4:0] ST_Q_UP    = 5'd19;
    localparam logic [4:0] ST_Q_UPW   = 5'd20;
    localparam logic [4:0] ST_Q_FIN   = 5'd21;
    localparam logic [4:0] ST_Q_FINW  = 5'd22;
    localparam logic [4:0] ST_Q_DEP   = 5'd23;
    localparam logic [4:0] ST_Q_DEPW  = 5'd24;
    localparam logic [4:0] ST_OUT     = 5'd25;

    function automatic logic in_range(input t_node n);
        return 32'(n) < MAX_NODES;
    endfunction

    // Memories and their registered read data.
    tlca_pkg::t_node_word r_node_mem [MAX_NODES];
    t_node                r_tbl_mem  [LEVELS][MAX_NODES];
    tlca_pkg::t_node_word r_node_qa, r_node_qb;
    t_node                r_tbl_qa, r_tbl_qb;

    logic                 node_we, node_rea, node_reb;
    t_addr                node_wa, node_raa, node_rab;
    tlca_pkg::t_node_word node_wd;
    logic                 tbl_we, tbl_rea, tbl_reb;
    t_lvl                 tbl_wl, tbl_rla, tbl_rlb;
    t_addr                tbl_wa, tbl_raa, tbl_rab;
    t_node                tbl_wd;

    // Control and working registers.
    logic [4:0]                  r_state, n_state;
    t_addr                       r_v, n_v;
    t_lvl                        r_lvl, n_lvl;
    logic                        r_changed, n_changed;
    logic                        r_built, n_built;
    logic                        r_ovalid, n_ovalid;
    t_node                       r_a, n_a, r_b, n_b, r_x, n_x, r_y, n_y;
    t_lift                       r_k, n_k;
    logic [DW-1:0]               r_da, n_da, r_db, n_db;
    t_node                       r_anc, n_anc, r_oanc, n_oanc;
    logic [tlca_pkg::LEN_W-1:0]  r_len, n_len, r_olen, n_olen;
    logic                        r_fault, n_fault, r_ofault, n_ofault;

    logic [tlca_pkg::CMD_W-1:0]  in_cmd;
    t_node                       in_a, in_b;
    logic [tlca_pkg::LEN_W-1:0]  q_len;

    assign in_cmd = s_axis_tuser;
    assign in_a   = s_axis_tdata[NW-1:0];
    assign in_b   = s_axis_tdata[2*NW-1:NW];
    assign q_len  = r_da + r_db - {r_node_qa.depth[DW-2:0], 1'b0};

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{PADW{1'b0}}, r_olen, r_oanc};
    assign m_axis_tuser  = r_ofault;

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            r_node_mem[node_wa] <= node_wd;
        end
        if (node_rea) begin
            r_node_qa <= r_node_mem[node_raa];
        end
        if (node_reb) begin
            r_node_qb <= r_node_mem[node_rab];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl_mem[tbl_wl][tbl_wa] <= tbl_wd;
        end
        if (tbl_rea) begin
            r_tbl_qa <= r_tbl_mem[tbl_rla][tbl_raa];
        end
        if (tbl_reb) begin
            r_tbl_qb <= r_tbl_mem[tbl_rlb][tbl_rab];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_v       = r_v;
        n_lvl     = r_lvl;
        n_changed = r_changed;
        n_built   = r_built;
        n_ovalid  = r_ovalid;
        n_a       = r_a;
        n_b       = r_b;
        n_x       = r_x;
        n_y       = r_y;
        n_k       = r_k;
        n_da      = r_da;
        n_db      = r_db;
        n_anc     = r_anc;
        n_len     = r_len;
        n_fault   = r_fault;
        n_oanc    = r_oanc;
        n_olen    = r_olen;
        n_ofault  = r_ofault;

        node_we  = 1'b0;
        node_wa  = r_v;
        node_wd  = r_node_qa;
        node_rea = 1'b0;
        node_raa = r_v;
        node_reb = 1'b0;
        node_rab = t_addr'(r_node_qa.parent);
        tbl_we   = 1'b0;
        tbl_wl   = r_lvl;
        tbl_wa   = r_v;
        tbl_wd   = r_tbl_qa;
        tbl_rea  = 1'b0;
        tbl_rla  = r_lvl;
        tbl_raa  = t_addr'(r_x);
        tbl_reb  = 1'b0;
        tbl_rlb  = r_lvl;
        tbl_rab  = t_addr'(r_y);

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_INIT: begin
                node_we = 1'b0 | 1'b1;
                node_wd = '0;
                if (r_v == LAST_NODE) begin
                    n_v     = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_v = r_v + t_addr'(1);
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    unique case (in_cmd)
                        tlca_pkg::CMD_LOAD: begin
                            if (in_range(in_a)) begin
                                node_we = 1'b1;
                                node_wa = t_addr'(in_a);
                                node_wd = '{present: 1'b1, reached: 1'b0,
                                            depth: '0, parent: in_b};
                                n_built = 1'b0;
                            end
                        end
                        tlca_pkg::CMD_BUILD: begin
                            if (in_range(in_a)) begin
                                n_a     = in_a;
                                n_state = ST_B_RD;
                            end
                        end
                        tlca_pkg::CMD_QUERY: begin
                            n_a     = in_a;
                            n_b     = in_b;
                            n_state = ST_Q_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_B_RD: begin
                node_rea = 1'b1;
                node_raa = t_addr'(r_a);
                n_state  = ST_B_CHK;
            end
            ST_B_CHK: begin
                if (r_node_qa.present) begin
                    n_v     = '0;
                    n_state = ST_CL_RD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_CL_RD: begin
                node_rea = 1'b1;
                n_state  = ST_CL_WR;
            end
            ST_CL_WR: begin
                node_we               = 1'b1;
                node_wd.reached       = (r_v == t_addr'(r_a));
                node_wd.depth         = '0;
                n_state               = ST_CL_RD;
                if (r_v == LAST_NODE) begin
                    n_v       = '0;
                    n_changed = 1'b0;
                    n_state   = ST_RX_RD;
                end else begin
                    n_v = r_v + t_addr'(1);
                end
            end
            ST_RX_RD: begin
                node_rea = 1'b1;
                n_state  = ST_RX_PAR;
            end
            ST_RX_PAR, ST_RX_UPD: begin
                if (r_state == ST_RX_PAR && r_node_qa.present && !r_node_qa.reached
                        && in_range(r_node_qa.parent)) begin
                    node_reb = 1'b1;
                    n_state  = ST_RX_UPD;
                end else begin
                    if (r_state == ST_RX_UPD && r_node_qb.reached) begin
                        node_we         = 1'b1;
                        node_wd.reached = 1'b1;
                        node_wd.depth   = r_node_qb.depth + DW'(1);
                        n_changed       = 1'b1;
                    end
                    n_state = ST_RX_RD;
                    if (r_v == LAST_NODE) begin
                        n_v       = '0;
                        n_changed = 1'b0;
                        if (!(r_changed || (r_state == ST_RX_UPD && r_node_qb.reached))) begin
                            n_state = ST_L0_RD;
                        end
                    end else begin
                        n_v = r_v + t_addr'(1);
                    end
                end
            end
            ST_L0_RD: begin
                node_rea = 1'b1;
                n_state  = ST_L0_WR;
            end
            ST_L0_WR: begin
                tbl_we  = 1'b1;
                tbl_wl  = '0;
                tbl_wd  = (r_v == t_addr'(r_a) || !r_node_qa.reached) ?
                          t_node'(r_v) : r_node_qa.parent;
                n_state = ST_L0_RD;
                if (r_v == LAST_NODE) begin
                    n_v     = '0;
                    n_lvl   = t_lvl'(1);
                    n_state = ST_LN_RD;
                end else begin
                    n_v = r_v + t_addr'(1);
                end
            end
            ST_LN_RD: begin
                tbl_rea = 1'b1;
                tbl_rla = r_lvl - t_lvl'(1);
                tbl_raa = r_v;
                n_state = ST_LN_RD2;
            end
            ST_LN_RD2: begin
                tbl_rea = 1'b1;
                tbl_rla = r_lvl - t_lvl'(1);
                tbl_raa = t_addr'(r_tbl_qa);
                n_state = ST_LN_WR;
            end
            ST_LN_WR: begin
                tbl_we  = 1'b1;
                n_state = ST_LN_RD;
                if (r_v == LAST_NODE) begin
                    n_v = '0;
                    if (r_lvl == TOP_LVL) begin
                        n_built = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_lvl = r_lvl + t_lvl'(1);
                    end
                end else begin
                    n_v = r_v + t_addr'(1);
                end
            end
            ST_Q_RD: begin
                if (!r_built || !in_range(r_a) || !in_range(r_b)) begin
                    n_anc   = '0;
                    n_len   = '0;
                    n_fault = 1'b1;
                    n_state = ST_OUT;
                end else begin
                    node_rea = 1'b1;
                    node_raa = t_addr'(r_a);
                    node_reb = 1'b1;
                    node_rab = t_addr'(r_b);
                    n_state  = ST_Q_CHK;
                end
            end
            ST_Q_CHK: begin
                if (!r_node_qa.reached || !r_node_qb.reached) begin
                    n_anc   = '0;
                    n_len   = '0;
                    n_fault = 1'b1;
                    n_state = ST_OUT;
                end else begin
                    n_da  = r_node_qa.depth;
                    n_db  = r_node_qb.depth;
                    n_lvl = TOP_LVL;
                    if (r_node_qa.depth < r_node_qb.depth) begin
                        n_x = r_b;
                        n_y = r_a;
                        n_k = t_lift'(r_node_qb.depth - r_node_qa.depth);
                    end else begin
                        n_x = r_a;
                        n_y = r_b;
                        n_k = t_lift'(r_node_qa.depth - r_node_qb.depth);
                    end
                    n_state = ST_Q_LIFT;
                end
            end
            ST_Q_LIFT: begin
                if (r_k[r_lvl]) begin
                    tbl_rea = 1'b1;
                    n_state = ST_Q_LIFTW;
                end else if (r_lvl == '0) begin
                    n_state = ST_Q_CMP;
                end else begin
                    n_lvl = r_lvl - t_lvl'(1);
                end
            end
            ST_Q_LIFTW: begin
                n_x = r_tbl_qa;
                if (r_lvl == '0) begin
                    n_state = ST_Q_CMP;
                end else begin
                    n_lvl   = r_lvl - t_lvl'(1);
                    n_state = ST_Q_LIFT;
                end
            end
            ST_Q_CMP: begin
                if (r_x == r_y) begin
                    n_state = ST_Q_DEP;
                end else begin
                    n_lvl   = TOP_LVL;
                    n_state = ST_Q_UP;
                end
            end
            ST_Q_UP: begin
                tbl_rea = 1'b1;
                tbl_reb = 1'b1;
                n_state = ST_Q_UPW;
            end
            ST_Q_UPW: begin
                if (r_tbl_qa != r_tbl_qb) begin
                    n_x = r_tbl_qa;
                    n_y = r_tbl_qb;
                end
                if (r_lvl == '0) begin
                    n_state = ST_Q_FIN;
                end else begin
                    n_lvl   = r_lvl - t_lvl'(1);
                    n_state = ST_Q_UP;
                end
            end
            ST_Q_FIN: begin
                tbl_rea = 1'b1;
                tbl_rla = '0;
                n_state = ST_Q_FINW;
            end
            ST_Q_FINW: begin
                n_x     = r_tbl_qa;
                n_state = ST_Q_DEP;
            end
            ST_Q_DEP: begin
                node_rea = 1'b1;
                node_raa = t_addr'(r_x);
                n_state  = ST_Q_DEPW;
            end
            ST_Q_DEPW: begin
                n_anc   = r_x;
                n_len   = q_len;
                n_fault = 1'b0;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_oanc   = r_anc;
                    n_olen   = r_len;
                    n_ofault = r_fault;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_v       <= '0;
            r_lvl     <= '0;
            r_changed <= 1'b0;
            r_built   <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_v       <= n_v;
            r_lvl     <= n_lvl;
            r_changed <= n_changed;
            r_built   <= n_built;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_b      <= n_b;
        r_x      <= n_x;
        r_y      <= n_y;
        r_k      <= n_k;
        r_da     <= n_da;
        r_db     <= n_db;
        r_anc    <= n_anc;
        r_len    <= n_len;
        r_fault  <= n_fault;
        r_oanc   <= n_oanc;
        r_olen   <= n_olen;
        r_ofault <= n_ofault;
    end

endmodule
`default_nettype wire

// ===== verif/tb_tree_lca_binary_lifting.sv =====
// ----------------------------------------------------------------------------
// tb_tree_lca_binary_lifting
// Self-checking bench for the binary-lifting lowest common ancestor block.
// ----------------------------------------------------------------------------
// The bench loads random trees node by node and builds each one from its
// root. It then asks for ancestors of random node pairs. A scoreboard keeps
// its own copy of the parent links, the reachability and depth of every node
// and the lifting table. It works out the answer to each query and compares
// each result beat with the oldest answer still outstanding. A short directed
// run covers queries without a table, self links, absent parents, absent
// roots, loads after a build, rebuilds from another root and the unused
// command code. Both stream sides pause at random, except in one steady phase.
// ----------------------------------------------------------------------------
module tb_tree_lca_binary_lifting;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES     = tlca_pkg::DEF_MAX_NODES;
    localparam int LIFT_LVLS = tlca_pkg::DEF_LEVELS;
    localparam logic [tlca_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef logic [tlca_pkg::NODE_W-1:0] t_node;

    typedef struct packed {
        logic [tlca_pkg::NODE_W-1:0] ancestor;
        logic [tlca_pkg::LEN_W-1:0]  path_length;
        logic                        fault;
    } t_lca_answer;

    class t_lca_tracker;
        t_node                        parent_of [NODES];
        bit                           present   [NODES];
        bit                           reached   [NODES];
        logic [tlca_pkg::DEPTH_W-1:0] level_of  [NODES];
        t_node                        lift      [LIFT_LVLS][NODES];
        bit                           built;
        t_lca_answer                  awaited_answers[$];
        int                           errors;

        function new();
            for (int v = 0; v < NODES; v++) begin
                parent_of[v] = '0;
                present[v]   = 1'b0;
                reached[v]   = 1'b0;
                level_of[v]  = '0;
                for (int i = 0; i < LIFT_LVLS; i++) begin
                    lift[i][v] = '0;
                end
            end
            built  = 1'b0;
            errors = 0;
        endfunction

        function void relink(input t_node root);
            bit    changed;
            t_node p;
            changed = 1'b1;
            foreach (reached[v]) reached[v] = 1'b0;
            reached[root]  = 1'b1;
            level_of[root] = '0;
            while (changed) begin
                changed = 1'b0;
                for (int v = 0; v < NODES; v++) begin
                    if (present[v] && !reached[v]) begin
                        p = parent_of[v];
                        if (reached[p]) begin
                            reached[v]  = 1'b1;
                            level_of[v] = level_of[p] + 11'd1;
                            changed     = 1'b1;
                        end
                    end
                end
            end
            for (int v = 0; v < NODES; v++) begin
                lift[0][v] = (t_node'(v) == root || !reached[v]) ? t_node'(v) : parent_of[v];
            end
            for (int i = 1; i < LIFT_LVLS; i++) begin
                for (int v = 0; v < NODES; v++) begin
                    lift[i][v] = lift[i-1][lift[i-1][v]];
                end
            end
        endfunction

        function t_node meet(input t_node a, input t_node b);
            t_node                        x;
            t_node                        y;
            t_node                        t;
            logic [tlca_pkg::DEPTH_W-1:0] k;
            x = a;
            y = b;
            if (level_of[x] < level_of[y]) begin
                t = x;
                x = y;
                y = t;
            end
            k = level_of[x] - level_of[y];
            for (int i = LIFT_LVLS - 1; i >= 0; i--) begin
                if (k[i]) x = lift[i][x];
            end
            if (x == y) return x;
            for (int i = LIFT_LVLS - 1; i >= 0; i--) begin
                if (lift[i][x] != lift[i][y]) begin
                    x = lift[i][x];
                    y = lift[i][y];
                end
            end
            return lift[0][x];
        endfunction

        function void note_beat(input logic [tlca_pkg::CMD_W-1:0] cmd, input t_node a,
                                input t_node b);
            t_lca_answer ans;
            t_node       m;
            case (cmd)
                tlca_pkg::CMD_LOAD: begin
                    parent_of[a] = b;
                    present[a]   = 1'b1;
                    built        = 1'b0;
                end
                tlca_pkg::CMD_BUILD: begin
                    if (present[a]) begin
                        relink(a);
                        built = 1'b1;
                    end
                end
                tlca_pkg::CMD_QUERY: begin
                    if (!built || !reached[a] || !reached[b]) begin
                        ans = '{ancestor: '0, path_length: '0, fault: 1'b1};
                    end else begin
                        m = meet(a, b);
                        ans.ancestor    = m;
                        ans.path_length = level_of[a] + level_of[b]
                                          - {level_of[m][tlca_pkg::DEPTH_W-2:0], 1'b0};
                        ans.fault       = 1'b0;
                    end
                    awaited_answers = {awaited_answers, ans};
                end
                default: begin
                end
            endcase
        endfunction

        function void check_answer(input t_node anc, input logic [tlca_pkg::LEN_W-1:0] len,
                                   input logic fault);
            t_lca_answer want;
            if (awaited_answers.size() == 0) begin
                $display("%0t: result beat with nothing outstanding: %s %0d %0d %0d",
                         $time, "ancestor, length, fault", anc, len, fault);
                errors++;
                return;
            end
            want = awaited_answers.pop_front();
            if (want.ancestor !== anc) begin
                $display("%0t: ancestor expected %0d actual %0d", $time, want.ancestor, anc);
                errors++;
            end
            if (want.path_length !== len) begin
                $display("%0t: path_length expected %0d actual %0d",
                         $time, want.path_length, len);
                errors++;
            end
            if (want.fault !== fault) begin
                $display("%0t: fault expected %0d actual %0d", $time, want.fault, fault);
                errors++;
            end
        endfunction
    endclass

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [tlca_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [tlca_pkg::CMD_W-1:0]       s_axis_tuser  = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b1;
    logic [tlca_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]                       m_axis_tuser;

    t_lca_tracker tracker = new();
    bit           steady  = 1'b0;

    tree_lca_binary_lifting dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_node pick_node();
        return t_node'($urandom_range(0, NODES - 1));
    endfunction

    task automatic send_beat(input logic [tlca_pkg::CMD_W-1:0] cmd, input t_node a,
                             input t_node b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{(tlca_pkg::IN_TDATA_W - 2 * tlca_pkg::NODE_W){1'b0}}, b, a};
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_beat(cmd, a, b);
    endtask

    task automatic grow_and_probe(input int count, input bit chain, input int probes);
        t_node members[$];
        t_node root;
        t_node v;
        t_node p;
        t_node x;
        t_node y;
        root = pick_node();
        send_beat(tlca_pkg::CMD_LOAD, root, pick_node());
        members = {members, root};
        for (int i = 1; i < count; i++) begin
            v = pick_node();
            p = chain ? members[members.size() - 1]
                      : members[$urandom_range(0, members.size() - 1)];
            send_beat(tlca_pkg::CMD_LOAD, v, p);
            members = {members, v};
            if ($urandom_range(0, 11) == 0) begin
                case ($urandom_range(0, 3))
                    0: begin
                        v = pick_node();
                        send_beat(tlca_pkg::CMD_LOAD, v, v);
                    end
                    1: send_beat(CMD_UNUSED, pick_node(), pick_node());
                    2: send_beat(tlca_pkg::CMD_QUERY, members[0], pick_node());
                    default: send_beat(tlca_pkg::CMD_LOAD, pick_node(), pick_node());
                endcase
            end
        end
        do v = pick_node(); while (tracker.present[v]);
        send_beat(tlca_pkg::CMD_BUILD, v, pick_node());
        send_beat(tlca_pkg::CMD_BUILD, root, pick_node());
        for (int q = 0; q < probes; q++) begin
            x = ($urandom_range(0, 6) == 0) ? pick_node()
                                            : members[$urandom_range(0, members.size() - 1)];
            if ($urandom_range(0, 15) == 0) begin
                y = x;
            end else begin
                y = ($urandom_range(0, 6) == 0) ? pick_node()
                                                : members[$urandom_range(0, members.size() - 1)];
            end
            if (q == probes - 12) begin
                send_beat(tlca_pkg::CMD_LOAD, pick_node(),
                          members[$urandom_range(0, members.size() - 1)]);
            end
            send_beat(tlca_pkg::CMD_QUERY, x, y);
        end
    endtask

    initial begin : drain_results
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                tracker.check_answer(m_axis_tdata[tlca_pkg::NODE_W-1:0],
                                     m_axis_tdata[tlca_pkg::NODE_W +: tlca_pkg::LEN_W],
                                     m_axis_tuser[0]);
                stall = steady ? 0 : $urandom_range(0, 8);
                if (stall > 0) m_axis_tready <= 1'b0;
            end else if (!m_axis_tready) begin
                stall--;
                if (stall <= 0) m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #80ms;
        $display("[tree_lca_binary_lifting] ERROR");
        $finish;
    end

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_beat(tlca_pkg::CMD_QUERY, 10'd5, 10'd7);
        send_beat(tlca_pkg::CMD_BUILD, 10'd3, 10'd0);
        send_beat(tlca_pkg::CMD_LOAD, 10'd0, 10'd1023);
        send_beat(tlca_pkg::CMD_LOAD, 10'd1023, 10'd0);
        send_beat(tlca_pkg::CMD_LOAD, 10'd512, 10'd1023);
        send_beat(tlca_pkg::CMD_LOAD, 10'd341, 10'd1023);
        send_beat(tlca_pkg::CMD_LOAD, 10'd682, 10'd512);
        send_beat(tlca_pkg::CMD_LOAD, 10'd7, 10'd7);
        send_beat(tlca_pkg::CMD_LOAD, 10'd100, 10'd200);
        send_beat(tlca_pkg::CMD_QUERY, 10'd682, 10'd341);
        send_beat(tlca_pkg::CMD_BUILD, 10'd0, 10'd1023);
        send_beat(tlca_pkg::CMD_QUERY, 10'd682, 10'd341);
        send_beat(tlca_pkg::CMD_QUERY, 10'd0, 10'd0);
        send_beat(tlca_pkg::CMD_QUERY, 10'd682, 10'd0);
        send_beat(tlca_pkg::CMD_QUERY, 10'd1023, 10'd1023);
        send_beat(tlca_pkg::CMD_QUERY, 10'd7, 10'd0);
        send_beat(tlca_pkg::CMD_QUERY, 10'd100, 10'd682);
        send_beat(tlca_pkg::CMD_QUERY, 10'd5, 10'd5);
        send_beat(CMD_UNUSED, 10'd1023, 10'd1023);
        send_beat(tlca_pkg::CMD_LOAD, 10'd5, 10'd682);
        send_beat(tlca_pkg::CMD_QUERY, 10'd682, 10'd341);
        send_beat(tlca_pkg::CMD_BUILD, 10'd682, 10'd341);
        send_beat(tlca_pkg::CMD_QUERY, 10'd5, 10'd682);
        send_beat(tlca_pkg::CMD_QUERY, 10'd0, 10'd5);

        for (int ph = 0; ph < 5; ph++) begin
            steady = (ph == 2);
            grow_and_probe($urandom_range(30, 70), 1'b0, 230);
        end
        steady = 1'b0;
        grow_and_probe(48, 1'b1, 200);

        s_axis_tvalid <= 1'b0;
        while (tracker.awaited_answers.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("[tree_lca_binary_lifting] OK");
        end else begin
            $display("[tree_lca_binary_lifting] ERROR");
        end
        $finish;
    end
endmodule
